>>> design/segment_circle_relation_core_defines.svh
// assertion macros shared by the segment circle relation design
`ifndef SEGMENT_CIRCLE_RELATION_CORE_DEFINES_SVH
`define SEGMENT_CIRCLE_RELATION_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/scr_pkg.sv
// shared types and codes of the segment circle relation design
`default_nettype none
package scr_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS   = 2'd2;

	// relation codes
	localparam int unsigned REL_WIDTH = 2;
	localparam logic [REL_WIDTH-1:0] REL_CROSS   = 2'd0;
	localparam logic [REL_WIDTH-1:0] REL_INSIDE  = 2'd1;
	localparam logic [REL_WIDTH-1:0] REL_OUTSIDE = 2'd2;

	// decision flags carried down the pipeline
	typedef struct packed {
		logic early;     // crossing known without the discriminant
		logic cand;      // crossing if the discriminant is not negative
		logic enclosed;  // both endpoints strictly within the radius
	} scr_flags_t;

endpackage
`default_nettype wire

>>> design/scr_mul_cell.sv
// registered signed multiplier cell used along the pipeline
`default_nettype none
module scr_mul_cell #(
	parameter int unsigned AW = 17,
	parameter int unsigned BW = 17
) (
	input  wire logic                 clk,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0]   p
);

	// one product per cycle, result registered
	always_ff @(posedge clk) begin
		p <= (AW+BW)'(a) * (AW+BW)'(b);
	end

endmodule
`default_nettype wire

>>> design/segment_circle_relation_core.sv
// top level of the segment circle relation classifier
// Classifies a segment (origin, target) against the configured circle.
// Input: a transaction is taken at each rising edge with start high and busy
// low. busy is always low, so one segment can enter every cycle.
// Output: relation appears for one cycle with done high once the segment
// has passed every stage; codes: crossing, wholly inside, outside.
// Throughput is one segment per cycle. The pipeline stages, in order, are
// differences, squares and dot products, sums, split partial products of
// the discriminant, wide sums, final compare.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write
// center_x (0), center_y (1) and radius (2); other indexes are ignored.
// cfg_ready is always high. Write only while no segment is in flight.
// Reset clears the pipeline valid bits and sets the centre to 0 and the
// radius to 1. The receiver cannot stall: done is a plain strobe.
`default_nettype none
`include "segment_circle_relation_core_defines.svh"
module segment_circle_relation_core #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [COORD_WIDTH-1:0]        origin_x,
	input  wire logic signed [COORD_WIDTH-1:0]        origin_y,
	input  wire logic signed [COORD_WIDTH-1:0]        target_x,
	input  wire logic signed [COORD_WIDTH-1:0]        target_y,
	output logic                                      done,
	output logic [scr_pkg::REL_WIDTH-1:0]             relation,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [scr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [COORD_WIDTH-1:0]               cfg_data
);

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned DW = W + 1;        // coordinate differences
	localparam int unsigned PW = 2 * DW;       // products of differences
	localparam int unsigned SW = 2 * W + 3;    // a, bh, c0, c1
	localparam int unsigned L  = W + 2;        // low split of SW values
	localparam int unsigned H  = SW - L;       // high split of SW values
	localparam int unsigned QW = 2 * SW;       // discriminant terms

	// configuration registers
	logic signed [W-1:0] center_x_q, center_y_q;
	logic        [W-1:0] radius_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				scr_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_data);
				scr_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_data);
				scr_pkg::REG_RADIUS:   radius_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: coordinate differences
	logic signed [DW-1:0] dx_s1, dy_s1, ex_s1, ey_s1, gx_s1, gy_s1, r_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= DW'(origin_x) - DW'(target_x);
		dy_s1 <= DW'(origin_y) - DW'(target_y);
		ex_s1 <= DW'(target_x) - DW'(center_x_q);
		ey_s1 <= DW'(target_y) - DW'(center_y_q);
		gx_s1 <= DW'(origin_x) - DW'(center_x_q);
		gy_s1 <= DW'(origin_y) - DW'(center_y_q);
		r_s1  <= $signed({1'b0, radius_q});
	end

	// stage 2: squares and dot products
	logic signed [PW-1:0] dxx_s2, dyy_s2, dxe_s2, dye_s2;
	logic signed [PW-1:0] exx_s2, eyy_s2, gxx_s2, gyy_s2, rr_s2;

	scr_mul_cell #(.AW(DW), .BW(DW)) u_dxx (.clk(clk), .a(dx_s1), .b(dx_s1), .p(dxx_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_dyy (.clk(clk), .a(dy_s1), .b(dy_s1), .p(dyy_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_dxe (.clk(clk), .a(dx_s1), .b(ex_s1), .p(dxe_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_dye (.clk(clk), .a(dy_s1), .b(ey_s1), .p(dye_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_exx (.clk(clk), .a(ex_s1), .b(ex_s1), .p(exx_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_eyy (.clk(clk), .a(ey_s1), .b(ey_s1), .p(eyy_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_gxx (.clk(clk), .a(gx_s1), .b(gx_s1), .p(gxx_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_gyy (.clk(clk), .a(gy_s1), .b(gy_s1), .p(gyy_s2));
	scr_mul_cell #(.AW(DW), .BW(DW)) u_rr  (.clk(clk), .a(r_s1),  .b(r_s1),  .p(rr_s2));

	// stage 3: quadratic coefficients
	logic signed [SW-1:0] a_s3, bh_s3, c0_s3, c1_s3;

	always_ff @(posedge clk) begin
		a_s3  <= SW'(dxx_s2) + SW'(dyy_s2);
		bh_s3 <= SW'(dxe_s2) + SW'(dye_s2);
		c0_s3 <= SW'(exx_s2) + SW'(eyy_s2) - SW'(rr_s2);
		c1_s3 <= SW'(gxx_s2) + SW'(gyy_s2) - SW'(rr_s2);
	end

	// stage 4 flags: sign tests and vertex range check
	logic signed [SW:0] near_sum;
	logic               a_nz, c0neg, c1neg, c0pos, c1pos, bh_np, near, both_in;
	scr_pkg::scr_flags_t flags_d, flags_s4, flags_s5;

	always_comb begin
		near_sum = (SW+1)'(a_s3) + (SW+1)'(bh_s3);
		a_nz     = a_s3 != '0;
		c0neg    = c0_s3[SW-1];
		c1neg    = c1_s3[SW-1];
		c0pos    = !c0neg && (c0_s3 != '0);
		c1pos    = !c1neg && (c1_s3 != '0);
		bh_np    = bh_s3[SW-1] || (bh_s3 == '0);
		near     = bh_np && !near_sum[SW];
		both_in  = c0neg && c1neg;
		flags_d.early    = a_nz && !both_in && (!c0pos || !c1pos);
		flags_d.cand     = a_nz && !both_in && near;
		flags_d.enclosed = both_in;
	end

	always_ff @(posedge clk) begin
		flags_s4 <= flags_d;
		flags_s5 <= flags_s4;
	end

	// stage 4 partial products of bh*bh and a*c0
	logic signed [H-1:0] bh_hi, a_hi, c0_hi;
	logic signed [L:0]   bh_lo, a_lo, c0_lo;

	assign bh_hi = $signed(bh_s3[SW-1:L]);
	assign a_hi  = $signed(a_s3[SW-1:L]);
	assign c0_hi = $signed(c0_s3[SW-1:L]);
	assign bh_lo = $signed({1'b0, bh_s3[L-1:0]});
	assign a_lo  = $signed({1'b0, a_s3[L-1:0]});
	assign c0_lo = $signed({1'b0, c0_s3[L-1:0]});

	logic signed [2*H-1:0]   bb_hh_s4, ac_hh_s4;
	logic signed [H+L:0]     bb_hl_s4, ac_hl_s4, ac_lh_s4;
	logic signed [2*L+1:0]   bb_ll_s4, ac_ll_s4;

	scr_mul_cell #(.AW(H),   .BW(H))   u_bb_hh (.clk(clk), .a(bh_hi), .b(bh_hi), .p(bb_hh_s4));
	scr_mul_cell #(.AW(H),   .BW(L+1)) u_bb_hl (.clk(clk), .a(bh_hi), .b(bh_lo), .p(bb_hl_s4));
	scr_mul_cell #(.AW(L+1), .BW(L+1)) u_bb_ll (.clk(clk), .a(bh_lo), .b(bh_lo), .p(bb_ll_s4));
	scr_mul_cell #(.AW(H),   .BW(H))   u_ac_hh (.clk(clk), .a(a_hi),  .b(c0_hi), .p(ac_hh_s4));
	scr_mul_cell #(.AW(H),   .BW(L+1)) u_ac_hl (.clk(clk), .a(a_hi),  .b(c0_lo), .p(ac_hl_s4));
	scr_mul_cell #(.AW(H),   .BW(L+1)) u_ac_lh (.clk(clk), .a(c0_hi), .b(a_lo),  .p(ac_lh_s4));
	scr_mul_cell #(.AW(L+1), .BW(L+1)) u_ac_ll (.clk(clk), .a(a_lo),  .b(c0_lo), .p(ac_ll_s4));

	// stage 5: reassemble bh*bh and a*c0
	logic signed [QW-1:0] bb_s5, ac_s5;

	always_ff @(posedge clk) begin
		bb_s5 <= (QW'(bb_hh_s4) <<< (2 * L)) + (QW'(bb_hl_s4) <<< (L + 1))
			+ QW'(bb_ll_s4);
		ac_s5 <= (QW'(ac_hh_s4) <<< (2 * L)) + ((QW'(ac_hl_s4) + QW'(ac_lh_s4)) <<< L)
			+ QW'(ac_ll_s4);
	end

	// stage 6: discriminant sign and final relation
	logic                         is_cross;
	logic [scr_pkg::REL_WIDTH-1:0] relation_s6;

	assign is_cross = flags_s5.early || (flags_s5.cand && (bb_s5 >= ac_s5));

	always_ff @(posedge clk) begin
		if (is_cross) begin
			relation_s6 <= scr_pkg::REL_CROSS;
		end else if (flags_s5.enclosed) begin
			relation_s6 <= scr_pkg::REL_INSIDE;
		end else begin
			relation_s6 <= scr_pkg::REL_OUTSIDE;
		end
	end

	assign done     = v_s6;
	assign relation = relation_s6;

	// checks: fixed latency, no spurious result and radius write
	`SCR_ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##6 done, "result missing after six cycles")
	`SCR_ASSERT_IMPL(a_no_spurious, clk, arst_n, !(start && !busy), ##6 !done, "result without a transaction")
	`SCR_ASSERT_NEXT(a_radius_write, clk, arst_n, cfg_valid && cfg_ready && (cfg_index == scr_pkg::REG_RADIUS), radius_q == $past(cfg_data), "radius write lost")

endmodule
`default_nettype wire
